// ===== rtl/core/tafl_pkg.sv =====
// ----------------------------------------------------------------------------
// tafl_pkg
// Shared types, codes and defaults of the tile animation frame lookup.
// ----------------------------------------------------------------------------
package tafl_pkg;

  localparam int MAX_FRAMES_DEF = 16;

  localparam int GID_W  = 24;
  localparam int LEN_W  = 16;
  localparam int TIME_W = 32;
  localparam int SUM_W  = 20;
  localparam int PIX_W  = 12;
  localparam int LOC_W  = 16;
  localparam int ADDR_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_RECT   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_FIRST_GID = 3'd0;
  localparam logic [2:0] REG_TILES     = 3'd1;
  localparam logic [2:0] REG_COLUMNS   = 3'd2;
  localparam logic [2:0] REG_TILE_W    = 3'd3;
  localparam logic [2:0] REG_TILE_H    = 3'd4;
  localparam logic [2:0] REG_MARGIN    = 3'd5;
  localparam logic [2:0] REG_SPACING   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_WALK_GO,
    ST_WALK_WAIT,
    ST_MEMB,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_READ,
    W_CHECK
  } walk_state_t;

  typedef struct packed {
    logic             done;
    logic [TIME_W-1:0] quot;
    logic [SUM_W-1:0]  rem;
  } div_res_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [GID_W-1:0] tile;
  } walk_res_t;

endpackage

// ===== rtl/core/tafl_ifs.sv =====
// ----------------------------------------------------------------------------
// tafl_ifs
// Valid/ready channel interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface tafl_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [tafl_pkg::GID_W-1:0]     tile_gid;
  logic [tafl_pkg::LEN_W-1:0]     frame_ms;
  logic [tafl_pkg::TIME_W-1:0]    time_ms;

  modport source (output valid, op, tile_gid, frame_ms, time_ms, input ready);
  modport sink   (input valid, op, tile_gid, frame_ms, time_ms, output ready);
endinterface

interface tafl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           in_set;
  logic [tafl_pkg::GID_W-1:0]     chosen_gid;
  logic [tafl_pkg::GID_W-1:0]     rect_left;
  logic [tafl_pkg::GID_W-1:0]     rect_top;
  logic [tafl_pkg::PIX_W-1:0]     rect_width;
  logic [tafl_pkg::PIX_W-1:0]     rect_height;
  logic [tafl_pkg::SUM_W-1:0]     total_ms;
  logic                           table_full;

  modport source (output valid, in_set, chosen_gid, rect_left, rect_top, rect_width,
                  rect_height, total_ms, table_full, input ready);
  modport sink   (input valid, in_set, chosen_gid, rect_left, rect_top, rect_width,
                  rect_height, total_ms, table_full, output ready);
endinterface

// ===== rtl/core/tafl_div.sv =====
// ----------------------------------------------------------------------------
// tafl_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tafl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tafl_pkg::TIME_W-1:0]   dividend,
  input  logic [tafl_pkg::SUM_W-1:0]    divisor,
  output tafl_pkg::div_res_t            res
);
  localparam int CNT_W = $clog2(tafl_pkg::TIME_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tafl_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [tafl_pkg::SUM_W-1:0]  dsr_r, dsr_nxt;
  logic [tafl_pkg::TIME_W-1:0] q_r, q_nxt;
  logic [tafl_pkg::SUM_W:0]    rem_s;
  logic [tafl_pkg::SUM_W:0]    diff;

  // Shift in the next dividend bit and try a subtract
  assign rem_s = {rem_r, q_r[tafl_pkg::TIME_W-1]};
  assign diff  = rem_s - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      if (rem_s >= {1'b0, dsr_r}) begin
        rem_nxt = diff[tafl_pkg::SUM_W-1:0];
        q_nxt   = {q_r[tafl_pkg::TIME_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[tafl_pkg::SUM_W-1:0];
        q_nxt   = {q_r[tafl_pkg::TIME_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(tafl_pkg::TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = rem_r;
endmodule

// ===== rtl/core/tafl_mul.sv =====
// ----------------------------------------------------------------------------
// tafl_mul
// Bit-serial shift-add multiplier, product kept modulo 2^24.
// ----------------------------------------------------------------------------
module tafl_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tafl_pkg::PIX_W:0]     mcand,
  input  logic [tafl_pkg::LOC_W-1:0]   mplier,
  output logic                         done,
  output logic [tafl_pkg::GID_W-1:0]   product
);
  localparam int CNT_W = $clog2(tafl_pkg::LOC_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tafl_pkg::GID_W-1:0]  a_r, a_nxt;
  logic [tafl_pkg::LOC_W-1:0]  b_r, b_nxt;
  logic [tafl_pkg::GID_W-1:0]  p_r, p_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = tafl_pkg::GID_W'(mcand);
      b_nxt    = mplier;
      p_nxt    = '0;
    end else if (busy_r) begin
      // Add the shifted multiplicand for each set multiplier bit
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt   = {a_r[tafl_pkg::GID_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[tafl_pkg::LOC_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(tafl_pkg::LOC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done    = done_r;
  assign product = p_r;
endmodule

// ===== rtl/core/tafl_walk.sv =====
// ----------------------------------------------------------------------------
// tafl_walk
// Frame table memory and the sequential walk that finds the current frame.
// ----------------------------------------------------------------------------
module tafl_walk #(
  parameter int MAX_FRAMES = tafl_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]     wr_idx,
  input  logic [tafl_pkg::GID_W-1:0]          wr_tile,
  input  logic [tafl_pkg::LEN_W-1:0]          wr_len,
  input  logic                                start,
  input  logic [tafl_pkg::SUM_W-1:0]          phase_ms,
  input  logic [$clog2(MAX_FRAMES+1)-1:0]     count,
  output tafl_pkg::walk_res_t                 res
);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int ACC_W = tafl_pkg::LEN_W + CNT_W;

  logic [tafl_pkg::GID_W-1:0] tile_mem [MAX_FRAMES];
  logic [tafl_pkg::LEN_W-1:0] len_mem  [MAX_FRAMES];

  tafl_pkg::walk_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [tafl_pkg::SUM_W-1:0] ph_r, ph_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [tafl_pkg::GID_W-1:0] rd_tile_r;
  logic [tafl_pkg::LEN_W-1:0] rd_len_r;
  logic                       done_r, done_nxt;
  logic                       found_r, found_nxt;
  logic [tafl_pkg::GID_W-1:0] pick_r, pick_nxt;
  logic [ACC_W-1:0]           acc_sum;

  // Write frames, read the current entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tile_mem[wr_idx[IDX_W-1:0]] <= wr_tile;
      len_mem[wr_idx[IDX_W-1:0]]  <= wr_len;
    end
    rd_tile_r <= tile_mem[idx_r[IDX_W-1:0]];
    rd_len_r  <= len_mem[idx_r[IDX_W-1:0]];
  end

  assign acc_sum = acc_r + ACC_W'(rd_len_r);

  // Advance one frame per pass through the read and check states
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    ph_nxt    = ph_r;
    n_nxt     = n_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    pick_nxt  = pick_r;
    case (state_r)
      tafl_pkg::W_IDLE: begin
        if (start) begin
          idx_nxt = '0;
          acc_nxt = '0;
          ph_nxt  = phase_ms;
          n_nxt   = count;
          if (count == '0) begin
            done_nxt  = 1'b1;
            found_nxt = 1'b0;
          end else begin
            state_nxt = tafl_pkg::W_READ;
          end
        end
      end
      tafl_pkg::W_READ: begin
        state_nxt = tafl_pkg::W_CHECK;
      end
      tafl_pkg::W_CHECK: begin
        acc_nxt = acc_sum;
        if (ACC_W'(ph_r) < acc_sum) begin
          done_nxt  = 1'b1;
          found_nxt = 1'b1;
          pick_nxt  = rd_tile_r;
          state_nxt = tafl_pkg::W_IDLE;
        end else if (idx_r + 1'b1 == n_r) begin
          done_nxt  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = tafl_pkg::W_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = tafl_pkg::W_READ;
        end
      end
      default: state_nxt = tafl_pkg::W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tafl_pkg::W_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    ph_r    <= ph_nxt;
    n_r     <= n_nxt;
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
  end

  assign res.done  = done_r;
  assign res.found = found_r;
  assign res.tile  = pick_r;
endmodule

// ===== rtl/core/tile_animation_frame_lookup.sv =====
// Flow: one item at a time; clear and append go straight to the output;
// a query with a nonzero duration sum divides the time by it in the serial
// divider and walks the frame table; a rectangle, or a query that finds a
// frame, runs the divider and both multipliers when the tile is in the set.
// Reset: synchronous active-low rst_n clears the frame count, the duration
// sum and the handshakes, and loads the register defaults.
// ----------------------------------------------------------------------------
// tile_animation_frame_lookup
// Animation frame selection and tile atlas rectangle, APB-configured.
// ----------------------------------------------------------------------------
module tile_animation_frame_lookup #(
  parameter int MAX_FRAMES = tafl_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tafl_in_if.sink                       in_chan,
  tafl_out_if.source                    out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tafl_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int GW    = tafl_pkg::GID_W;
  localparam int PW    = tafl_pkg::PIX_W;
  localparam int SW    = tafl_pkg::SUM_W;

  // Configuration registers
  logic [GW-1:0]              first_gid_r;
  logic [tafl_pkg::LOC_W-1:0] tiles_r;
  logic [PW-1:0]              cols_r, tile_w_r, tile_h_r, margin_r, spacing_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gid_r <= GW'(1);
      tiles_r     <= '0;
      cols_r      <= PW'(1);
      tile_w_r    <= PW'(16);
      tile_h_r    <= PW'(16);
      margin_r    <= '0;
      spacing_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        tafl_pkg::REG_FIRST_GID: first_gid_r <= cfg_pwdata[GW-1:0];
        tafl_pkg::REG_TILES:     tiles_r     <= cfg_pwdata[tafl_pkg::LOC_W-1:0];
        tafl_pkg::REG_COLUMNS:   cols_r      <= cfg_pwdata[PW-1:0];
        tafl_pkg::REG_TILE_W:    tile_w_r    <= cfg_pwdata[PW-1:0];
        tafl_pkg::REG_TILE_H:    tile_h_r    <= cfg_pwdata[PW-1:0];
        tafl_pkg::REG_MARGIN:    margin_r    <= cfg_pwdata[PW-1:0];
        tafl_pkg::REG_SPACING:   spacing_r   <= cfg_pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[4:2])
      tafl_pkg::REG_FIRST_GID: cfg_prdata = 32'(first_gid_r);
      tafl_pkg::REG_TILES:     cfg_prdata = 32'(tiles_r);
      tafl_pkg::REG_COLUMNS:   cfg_prdata = 32'(cols_r);
      tafl_pkg::REG_TILE_W:    cfg_prdata = 32'(tile_w_r);
      tafl_pkg::REG_TILE_H:    cfg_prdata = 32'(tile_h_r);
      tafl_pkg::REG_MARGIN:    cfg_prdata = 32'(margin_r);
      tafl_pkg::REG_SPACING:   cfg_prdata = 32'(spacing_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Control and item state
  tafl_pkg::ctl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SW-1:0]               sum_r, sum_nxt;
  logic [tafl_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [GW-1:0]               sel_r, sel_nxt;
  logic                        has_r, has_nxt;
  logic                        full_r, full_nxt;
  logic                        memb_r, memb_nxt;
  logic [tafl_pkg::LOC_W-1:0]  loc_r, loc_nxt;
  logic [PW-1:0]               x_r, x_nxt;
  logic [tafl_pkg::LOC_W-1:0]  y_r, y_nxt;
  logic [GW-1:0]               left_r, left_nxt;
  logic [GW-1:0]               top_r, top_nxt;

  // Output register
  logic          ov_r, ov_nxt;
  logic          o_in_set_r;
  logic [GW-1:0] o_gid_r, o_left_r, o_top_r;
  logic [PW-1:0] o_w_r, o_h_r;
  logic [SW-1:0] o_total_r;
  logic          o_full_r;
  logic          load_out;

  // Units
  logic                        div_start, mul_start, wr_en, walk_start;
  logic [tafl_pkg::TIME_W-1:0] div_dvd;
  logic [SW-1:0]               div_dsr;
  tafl_pkg::div_res_t          div_res;
  tafl_pkg::walk_res_t         walk_res;
  logic                        mulx_done, muly_done;
  logic [GW-1:0]               mulx_p, muly_p;
  logic [PW-1:0]               cols_eff;
  logic [SW:0]                 sum_add;
  logic [GW:0]                 lim;
  logic                        memb_c;
  logic [GW-1:0]               loc_full;
  logic                        accept;

  assign accept   = in_chan.valid & in_chan.ready;
  assign cols_eff = (cols_r == '0) ? PW'(1) : cols_r;
  assign sum_add  = {1'b0, sum_r} + (SW+1)'(in_chan.frame_ms);
  assign lim      = {1'b0, first_gid_r} + (GW+1)'(tiles_r);
  assign memb_c   = (sel_r >= first_gid_r) && ({1'b0, sel_r} < lim);
  assign loc_full = sel_r - first_gid_r;

  tafl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .res      (div_res)
  );

  tafl_walk #(.MAX_FRAMES(MAX_FRAMES)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_idx   (cnt_r),
    .wr_tile  (in_chan.tile_gid),
    .wr_len   (in_chan.frame_ms),
    .start    (walk_start),
    .phase_ms (div_res.rem),
    .count    (cnt_r),
    .res      (walk_res)
  );

  tafl_mul u_mulx (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   ({1'b0, tile_w_r} + {1'b0, spacing_r}),
    .mplier  (tafl_pkg::LOC_W'(x_r)),
    .done    (mulx_done),
    .product (mulx_p)
  );

  tafl_mul u_muly (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   ({1'b0, tile_h_r} + {1'b0, spacing_r}),
    .mplier  (y_r),
    .done    (muly_done),
    .product (muly_p)
  );

  assign in_chan.ready = (state_r == tafl_pkg::ST_IDLE);

  // Sequence one item through the units
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    time_nxt   = time_r;
    sel_nxt    = sel_r;
    has_nxt    = has_r;
    full_nxt   = full_r;
    memb_nxt   = memb_r;
    loc_nxt    = loc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    div_start  = 1'b0;
    div_dvd    = time_r;
    div_dsr    = sum_r;
    mul_start  = 1'b0;
    wr_en      = 1'b0;
    walk_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      tafl_pkg::ST_IDLE: begin
        if (accept) begin
          full_nxt = 1'b0;
          has_nxt  = 1'b0;
          memb_nxt = 1'b0;
          time_nxt = in_chan.time_ms;
          sel_nxt  = in_chan.tile_gid;
          state_nxt = tafl_pkg::ST_OUT;
          case (in_chan.op)
            tafl_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
              sum_nxt = '0;
            end
            tafl_pkg::OP_APPEND: begin
              if (cnt_r >= CNT_W'(MAX_FRAMES)) begin
                full_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                sum_nxt = sum_add[SW] ? tafl_pkg::SUM_MAX : sum_add[SW-1:0];
              end
            end
            tafl_pkg::OP_QUERY: begin
              if (sum_r != '0) begin
                state_nxt = tafl_pkg::ST_MOD_GO;
              end
            end
            tafl_pkg::OP_RECT: begin
              has_nxt   = 1'b1;
              state_nxt = tafl_pkg::ST_MEMB;
            end
            default: ;
          endcase
        end
      end
      tafl_pkg::ST_MOD_GO: begin
        div_start = 1'b1;
        state_nxt = tafl_pkg::ST_MOD_WAIT;
      end
      tafl_pkg::ST_MOD_WAIT: begin
        if (div_res.done) begin
          state_nxt = tafl_pkg::ST_WALK_GO;
        end
      end
      tafl_pkg::ST_WALK_GO: begin
        walk_start = 1'b1;
        state_nxt  = tafl_pkg::ST_WALK_WAIT;
      end
      tafl_pkg::ST_WALK_WAIT: begin
        if (walk_res.done) begin
          if (walk_res.found) begin
            has_nxt   = 1'b1;
            sel_nxt   = walk_res.tile;
            state_nxt = tafl_pkg::ST_MEMB;
          end else begin
            state_nxt = tafl_pkg::ST_OUT;
          end
        end
      end
      tafl_pkg::ST_MEMB: begin
        memb_nxt  = memb_c;
        loc_nxt   = loc_full[tafl_pkg::LOC_W-1:0];
        state_nxt = memb_c ? tafl_pkg::ST_DIV_GO : tafl_pkg::ST_OUT;
      end
      tafl_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        div_dvd   = tafl_pkg::TIME_W'(loc_r);
        div_dsr   = SW'(cols_eff);
        state_nxt = tafl_pkg::ST_DIV_WAIT;
      end
      tafl_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          x_nxt     = div_res.rem[PW-1:0];
          y_nxt     = div_res.quot[tafl_pkg::LOC_W-1:0];
          state_nxt = tafl_pkg::ST_MUL_GO;
        end
      end
      tafl_pkg::ST_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = tafl_pkg::ST_MUL_WAIT;
      end
      tafl_pkg::ST_MUL_WAIT: begin
        if (mulx_done && muly_done) begin
          left_nxt  = GW'(margin_r) + mulx_p;
          top_nxt   = GW'(margin_r) + muly_p;
          state_nxt = tafl_pkg::ST_OUT;
        end
      end
      tafl_pkg::ST_OUT: begin
        if (!ov_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = tafl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tafl_pkg::ST_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    ov_nxt = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tafl_pkg::ST_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    sel_r  <= sel_nxt;
    has_r  <= has_nxt;
    full_r <= full_nxt;
    memb_r <= memb_nxt;
    loc_r  <= loc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    left_r <= left_nxt;
    top_r  <= top_nxt;
    if (load_out) begin
      o_in_set_r <= memb_r & has_r;
      o_gid_r    <= has_r ? sel_r : '1;
      o_left_r   <= (memb_r & has_r) ? left_r : '0;
      o_top_r    <= (memb_r & has_r) ? top_r : '0;
      o_w_r      <= (memb_r & has_r) ? tile_w_r : '0;
      o_h_r      <= (memb_r & has_r) ? tile_h_r : '0;
      o_total_r  <= sum_r;
      o_full_r   <= full_r;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.in_set      = o_in_set_r;
  assign out_chan.chosen_gid  = o_gid_r;
  assign out_chan.rect_left   = o_left_r;
  assign out_chan.rect_top    = o_top_r;
  assign out_chan.rect_width  = o_w_r;
  assign out_chan.rect_height = o_h_r;
  assign out_chan.total_ms    = o_total_r;
  assign out_chan.table_full  = o_full_r;
endmodule
